FILE: src/cclh_pkg.sv
// ----------------------------------------------------------------------------
// cclh_pkg: shared types and constants for the character-class line histogram
// Holds the action codes, the command and result beats that pass between the
// front end, the queues and the back end, and the byte classifier functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cclh_pkg;

  // Field widths fixed by the interface
  localparam int CLASS_W     = 4;
  localparam int LEN_W       = 10;
  localparam int MASK_W      = 15;
  localparam int REPLY_W     = 32;
  localparam int NUM_CLASSES = 15;

  localparam logic [LEN_W-1:0]  LEN_SAT    = 10'd1023;
  localparam logic [7:0]        NEWLINE    = 8'h0A;
  localparam logic [MASK_W-1:0] MASK_ALL   = 15'h7FFF;
  localparam logic [MASK_W-1:0] MASK_DIGIT = 15'h5C71;
  localparam logic [MASK_W-1:0] MASK_LOWER = 15'h6D92;
  localparam logic [MASK_W-1:0] MASK_UPPER = 15'h76A4;
  localparam logic [MASK_W-1:0] MASK_OTHER = 15'h7B48;

  localparam logic REPLY_LINE = 1'b0;
  localparam logic REPLY_READ = 1'b1;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_LENGTH  = 12;
  localparam int DEF_COUNT_WIDTH = 32;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    ACT_BYTE     = 2'd0,
    ACT_RD_TOTAL = 2'd1,
    ACT_RD_BIN   = 2'd2,
    ACT_RD_GRAND = 2'd3
  } action_t;

  // Work handed from the front end to the back end
  typedef struct packed {
    action_t            op;   // ACT_BYTE marks a finished line
    logic [CLASS_W-1:0] cls;  // line class or class selector
    logic [LEN_W-1:0]   len;  // line length or length selector
    logic               ovf;  // line too long for a length bin
    logic               bad;  // selector out of range, read returns zero
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic               reply_kind;
    logic [CLASS_W-1:0] line_class;
    logic [LEN_W-1:0]   line_length;
    logic               length_overflow;
    logic [REPLY_W-1:0] count_value;
  } res_t;

  // Class mask of one text byte
  function automatic logic [MASK_W-1:0] byte_mask(input logic [7:0] b);
    logic [MASK_W-1:0] m;
    begin
      if (b >= 8'h30 && b <= 8'h39) m = MASK_DIGIT;
      else if (b >= 8'h61 && b <= 8'h7A) m = MASK_LOWER;
      else if (b >= 8'h41 && b <= 8'h5A) m = MASK_UPPER;
      else m = MASK_OTHER;
      return m;
    end
  endfunction

  // Index of the lowest set bit; an empty mask picks the last class
  function automatic logic [CLASS_W-1:0] lowest_class(input logic [MASK_W-1:0] m);
    logic [CLASS_W-1:0] c;
    begin
      c = CLASS_W'(NUM_CLASSES - 1);
      for (int i = MASK_W - 1; i >= 0; i--) begin
        if (m[i]) c = CLASS_W'(i);
      end
      return c;
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/cclh_fifo.sv
// ----------------------------------------------------------------------------
// cclh_fifo: small register queue
// Decouples two sides with push/full and pop/empty; data shows at the head
// while empty is low.
// ----------------------------------------------------------------------------
`default_nettype none

module cclh_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

FILE: src/cclh_front.sv
// ----------------------------------------------------------------------------
// cclh_front: byte classifier and line tracker
// Folds each text byte into the running class mask and length; on a newline
// or a read action, emits one command beat for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cclh_front #(
  parameter int MAX_LENGTH = cclh_pkg::DEF_MAX_LENGTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [1:0]                     action,
  input  wire logic [7:0]                     char_byte,
  input  wire logic [cclh_pkg::CLASS_W-1:0]   class_select,
  input  wire logic [3:0]                     length_select,
  output logic                                cmd_push,
  output cclh_pkg::cmd_t                      cmd
);

  logic [cclh_pkg::MASK_W-1:0] class_mask;
  logic [cclh_pkg::LEN_W-1:0]  current_length;
  cclh_pkg::action_t           act;
  logic                        is_newline;

  assign act        = cclh_pkg::action_t'(action);
  assign is_newline = (char_byte == cclh_pkg::NEWLINE);
  assign cmd_push   = accept && ((act != cclh_pkg::ACT_BYTE) || is_newline);

  // Build the command beat
  always_comb begin
    cmd.op  = act;
    cmd.cls = class_select;
    cmd.len = cclh_pkg::LEN_W'(length_select);
    cmd.ovf = 1'b0;
    cmd.bad = (class_select > cclh_pkg::CLASS_W'(cclh_pkg::NUM_CLASSES - 1)) ||
              ((act == cclh_pkg::ACT_RD_BIN) &&
               (cclh_pkg::LEN_W'(length_select) >= cclh_pkg::LEN_W'(MAX_LENGTH)));
    if (act == cclh_pkg::ACT_BYTE) begin
      cmd.cls = cclh_pkg::lowest_class(class_mask);
      cmd.len = current_length;
      cmd.ovf = (current_length >= cclh_pkg::LEN_W'(MAX_LENGTH));
      cmd.bad = 1'b0;
    end
  end

  // Fold text bytes into the line state; restart on newline
  always_ff @(posedge clk) begin
    if (rst) begin
      class_mask     <= cclh_pkg::MASK_ALL;
      current_length <= '0;
    end else if (accept && (act == cclh_pkg::ACT_BYTE)) begin
      if (is_newline) begin
        class_mask     <= cclh_pkg::MASK_ALL;
        current_length <= '0;
      end else begin
        class_mask <= class_mask & cclh_pkg::byte_mask(char_byte);
        if (current_length != cclh_pkg::LEN_SAT) current_length <= current_length + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/cclh_back.sv
// ----------------------------------------------------------------------------
// cclh_back: counter store and read-out
// Two stages: the first takes a command and reads the length bin memory, the
// second updates the saturating counters and emits the result beat. Clears
// the bin memory one entry per cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cclh_back #(
  parameter int MAX_LENGTH  = cclh_pkg::DEF_MAX_LENGTH,
  parameter int COUNT_WIDTH = cclh_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_empty,
  input  wire cclh_pkg::cmd_t  cmd_head,
  output logic                 cmd_pop,
  input  wire logic            res_full,
  output logic                 res_push,
  output cclh_pkg::res_t       res,
  output logic                 clearing
);

  localparam int BINS      = cclh_pkg::NUM_CLASSES * MAX_LENGTH;
  localparam int ADDR_W    = $clog2(BINS);
  localparam int LEN_IDX_W = $clog2(MAX_LENGTH);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Saturating increment
  function automatic count_t sat_inc(input count_t v);
    begin
      return (v == '1) ? v : v + 1'b1;
    end
  endfunction

  // Clip a counter to the 32-bit reply field
  function automatic logic [cclh_pkg::REPLY_W-1:0] clip_reply(input count_t v);
    logic [63:0] w;
    begin
      w = 64'(v);
      return (|w[63:32]) ? '1 : w[31:0];
    end
  endfunction

  count_t               bin_mem [BINS];
  count_t               bin_rd;
  count_t               class_totals [cclh_pkg::NUM_CLASSES];
  count_t               grand_total;

  logic                 clr_busy;
  logic [ADDR_W-1:0]    clr_addr;

  logic                 s2_valid;
  cclh_pkg::cmd_t       s2_cmd;
  logic [ADDR_W-1:0]    s2_addr;
  logic                 s2_go;

  logic                 fwd_valid;
  logic [ADDR_W-1:0]    fwd_addr;
  count_t               fwd_data;

  logic                 use_bin;
  logic [ADDR_W-1:0]    rd_addr;
  count_t               bin_cur;
  count_t               bin_new;
  count_t               tot_cur;
  logic                 bin_we;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  count_t               mem_wd;

  assign clearing = clr_busy;
  assign s2_go    = s2_valid && !res_full;
  assign cmd_pop  = !cmd_empty && !clr_busy && (!s2_valid || s2_go);
  assign res_push = s2_go;

  // Bin address of the head command; unused commands read entry zero
  always_comb begin
    use_bin = ((cmd_head.op == cclh_pkg::ACT_BYTE) && !cmd_head.ovf) ||
              ((cmd_head.op == cclh_pkg::ACT_RD_BIN) && !cmd_head.bad);
    rd_addr = '0;
    if (use_bin) begin
      rd_addr = ADDR_W'(ADDR_W'(cmd_head.cls) * ADDR_W'(MAX_LENGTH)) +
                ADDR_W'(cmd_head.len[LEN_IDX_W-1:0]);
    end
  end

  // Current bin value, taking the write that the registered read missed
  assign bin_cur = (fwd_valid && (fwd_addr == s2_addr)) ? fwd_data : bin_rd;
  assign bin_new = sat_inc(bin_cur);
  assign tot_cur = (s2_cmd.cls < cclh_pkg::CLASS_W'(cclh_pkg::NUM_CLASSES)) ?
                   class_totals[s2_cmd.cls] : '0;
  assign bin_we  = s2_go && (s2_cmd.op == cclh_pkg::ACT_BYTE) && !s2_cmd.ovf;

  // Memory write port: clearing sweep or bin update
  always_comb begin
    mem_we = clr_busy || bin_we;
    mem_wa = clr_busy ? clr_addr : s2_addr;
    mem_wd = clr_busy ? '0 : bin_new;
  end

  always_ff @(posedge clk) begin
    if (mem_we) bin_mem[mem_wa] <= mem_wd;
    if (cmd_pop) bin_rd <= bin_mem[rd_addr];
  end

  // Hold the last write for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (mem_we) begin
      fwd_valid <= 1'b1;
    end
    if (mem_we) begin
      fwd_addr <= mem_wa;
      fwd_data <= mem_wd;
    end
  end

  // Sweep the bin memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == ADDR_W'(BINS - 1)) clr_busy <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Second stage: advance the command, update the counters
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid    <= 1'b0;
      grand_total <= '0;
      for (int i = 0; i < cclh_pkg::NUM_CLASSES; i++) class_totals[i] <= '0;
    end else begin
      if (cmd_pop) s2_valid <= 1'b1;
      else if (s2_go) s2_valid <= 1'b0;
      if (s2_go && (s2_cmd.op == cclh_pkg::ACT_BYTE)) begin
        class_totals[s2_cmd.cls] <= sat_inc(tot_cur);
        grand_total              <= sat_inc(grand_total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s2_cmd  <= cmd_head;
      s2_addr <= rd_addr;
    end
  end

  // Result beat
  always_comb begin
    res.reply_kind      = cclh_pkg::REPLY_READ;
    res.line_class      = '0;
    res.line_length     = '0;
    res.length_overflow = 1'b0;
    res.count_value     = '0;
    unique case (s2_cmd.op)
      cclh_pkg::ACT_BYTE: begin
        res.reply_kind      = cclh_pkg::REPLY_LINE;
        res.line_class      = s2_cmd.cls;
        res.line_length     = s2_cmd.len;
        res.length_overflow = s2_cmd.ovf;
      end
      cclh_pkg::ACT_RD_TOTAL: begin
        if (!s2_cmd.bad) res.count_value = clip_reply(tot_cur);
      end
      cclh_pkg::ACT_RD_BIN: begin
        if (!s2_cmd.bad) res.count_value = clip_reply(bin_cur);
      end
      cclh_pkg::ACT_RD_GRAND: begin
        res.count_value = clip_reply(grand_total);
      end
      default: res.count_value = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/char_class_line_histogram.sv
// ----------------------------------------------------------------------------
// char_class_line_histogram: line counter by character classes and length
// Classes text bytes, sorts finished lines into class combinations and
// length bins with saturating counters, and answers counter reads.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake         Beat contents
//  -------  ----------------  ---------------------------------------------
//  input    push / full       action, char_byte, class_select, length_select
//  result   pop / empty       reply_kind, line_class, line_length,
//                             length_overflow, count_value
//
//  One input beat per cycle is taken while full is low; a text byte other than
//  newline gives no result. A newline or a read passes through the command
//  queue, bin memory read stage, update stage and result queue before its
//  result shows. After reset, full stays high while the length bin memory is
//  swept to zero. A stalled result side fills the result and command queues;
//  text bytes are still taken until the command queue is full.
//
// ----------------------------------------------------------------------------
`default_nettype none

module char_class_line_histogram #(
  parameter int MAX_LENGTH  = cclh_pkg::DEF_MAX_LENGTH,
  parameter int COUNT_WIDTH = cclh_pkg::DEF_COUNT_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [1:0]                        action,
  input  wire logic [7:0]                        char_byte,
  input  wire logic [cclh_pkg::CLASS_W-1:0]      class_select,
  input  wire logic [3:0]                        length_select,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   reply_kind,
  output logic [cclh_pkg::CLASS_W-1:0]           line_class,
  output logic [cclh_pkg::LEN_W-1:0]             line_length,
  output logic                                   length_overflow,
  output logic [cclh_pkg::REPLY_W-1:0]           count_value
);

  localparam int CMD_W = $bits(cclh_pkg::cmd_t);
  localparam int RES_W = $bits(cclh_pkg::res_t);

  logic               accept;
  logic               cmd_push;
  cclh_pkg::cmd_t     cmd_in;
  logic [CMD_W-1:0]   cmd_head_bits;
  cclh_pkg::cmd_t     cmd_head;
  logic               cmd_full;
  logic               cmd_empty;
  logic               cmd_pop;
  logic               res_full;
  logic               res_push;
  cclh_pkg::res_t     res_in;
  logic [RES_W-1:0]   res_head_bits;
  cclh_pkg::res_t     res_head;
  logic               clearing;

  // Hold off input while the command queue is full or the bins are cleared
  assign full   = cmd_full || clearing;
  assign accept = push && !full;

  cclh_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .action        (action),
    .char_byte     (char_byte),
    .class_select  (class_select),
    .length_select (length_select),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  cclh_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (cclh_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head_bits),
    .empty     (cmd_empty)
  );

  assign cmd_head = cclh_pkg::cmd_t'(cmd_head_bits);

  cclh_back #(
    .MAX_LENGTH  (MAX_LENGTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .clearing  (clearing)
  );

  cclh_fifo #(
    .WIDTH (RES_W),
    .DEPTH (cclh_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_head_bits),
    .empty     (empty)
  );

  // Drive the result ports from the queue head
  assign res_head        = cclh_pkg::res_t'(res_head_bits);
  assign reply_kind      = res_head.reply_kind;
  assign line_class      = res_head.line_class;
  assign line_length     = res_head.line_length;
  assign length_overflow = res_head.length_overflow;
  assign count_value     = res_head.count_value;

endmodule

`default_nettype wire

FILE: verif/char_class_line_histogram_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_class_line_histogram_tb: self-checking bench for the line histogram
// Drives text bytes and counter reads through the push/full queue interface,
// predicts every newline and read reply in a scoreboard object, and checks
// each popped result field by field.
// ----------------------------------------------------------------------------

module char_class_line_histogram_tb;

  localparam int MAXLEN    = cclh_pkg::DEF_MAX_LENGTH;
  localparam int CNT_W     = cclh_pkg::DEF_COUNT_WIDTH;
  localparam int NUM_COMBO = 15;
  localparam int LIMIT     = 500000;

  localparam logic [14:0] MK_ALL   = 15'h7FFF;
  localparam logic [14:0] MK_DIGIT = 15'h5C71;
  localparam logic [14:0] MK_LOWER = 15'h6D92;
  localparam logic [14:0] MK_UPPER = 15'h76A4;
  localparam logic [14:0] MK_OTHER = 15'h7B48;
  localparam logic [9:0]  LEN_TOP  = 10'd1023;
  localparam logic [7:0]  LF       = 8'h0A;

  typedef struct {
    cclh_pkg::action_t act;
    logic [7:0]        ch;
    logic [3:0]        csel;
    logic [3:0]        lsel;
  } beat_t;

  logic       clk;
  logic       rst           = 1'b1;
  logic       push          = 1'b0;
  logic [1:0] action        = cclh_pkg::ACT_BYTE;
  logic [7:0] char_byte     = 8'd0;
  logic [3:0] class_select  = 4'd0;
  logic [3:0] length_select = 4'd0;
  logic       pop           = 1'b0;
  logic       full;
  logic       empty;
  logic       reply_kind;
  logic [cclh_pkg::CLASS_W-1:0] line_class;
  logic [cclh_pkg::LEN_W-1:0]   line_length;
  logic                         length_overflow;
  logic [cclh_pkg::REPLY_W-1:0] count_value;

  int cycle_count = 0;
  int burst_left  = 0;
  int beats_sent  = 0;
  int stall_left  = 0;

  char_class_line_histogram u_top (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .action          (action),
    .char_byte       (char_byte),
    .class_select    (class_select),
    .length_select   (length_select),
    .empty           (empty),
    .pop             (pop),
    .reply_kind      (reply_kind),
    .line_class      (line_class),
    .line_length     (line_length),
    .length_overflow (length_overflow),
    .count_value     (count_value)
  );

  // Class mask that one text byte leaves in the running line mask
  function automatic logic [14:0] char_class_mask(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return MK_DIGIT;
    if (ch >= 8'h61 && ch <= 8'h7A) return MK_LOWER;
    if (ch >= 8'h41 && ch <= 8'h5A) return MK_UPPER;
    return MK_OTHER;
  endfunction

  // Combination picked by the lowest set mask bit; an empty mask picks the top
  function automatic int first_combo(input logic [14:0] m);
    for (int i = 0; i < NUM_COMBO; i++) begin
      if (m[i]) return i;
    end
    return NUM_COMBO - 1;
  endfunction

  class line_scoreboard;
    logic [14:0]      run_mask;
    logic [9:0]       run_len;
    logic [CNT_W-1:0] combo_total [NUM_COMBO];
    logic [CNT_W-1:0] len_hist [NUM_COMBO*MAXLEN];
    logic [CNT_W-1:0] line_count;
    cclh_pkg::res_t   awaited [$];
    int               errors;

    function new();
      run_mask   = MK_ALL;
      run_len    = '0;
      line_count = '0;
      errors     = 0;
      foreach (combo_total[i]) combo_total[i] = '0;
      foreach (len_hist[i]) len_hist[i] = '0;
    endfunction

    function logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Advance the line state for one accepted beat and queue its reply
    function void tally_beat(input beat_t b);
      cclh_pkg::res_t   r;
      int               combo;
      logic             ovf;
      logic [CNT_W-1:0] val;
      r   = '0;
      val = '0;
      case (b.act)
        cclh_pkg::ACT_BYTE: begin
          if (b.ch != LF) begin
            run_mask &= char_class_mask(b.ch);
            if (run_len != LEN_TOP) run_len++;
            return;
          end
          combo = first_combo(run_mask);
          ovf   = (run_len >= MAXLEN);
          combo_total[combo] = sat_up(combo_total[combo]);
          if (!ovf) begin
            len_hist[combo*MAXLEN + int'(run_len)] =
              sat_up(len_hist[combo*MAXLEN + int'(run_len)]);
          end
          line_count          = sat_up(line_count);
          r.reply_kind        = cclh_pkg::REPLY_LINE;
          r.line_class        = combo[cclh_pkg::CLASS_W-1:0];
          r.line_length       = run_len;
          r.length_overflow   = ovf;
          run_mask            = MK_ALL;
          run_len             = '0;
        end
        cclh_pkg::ACT_RD_TOTAL: begin
          if (b.csel < NUM_COMBO) val = combo_total[b.csel];
          r.reply_kind  = cclh_pkg::REPLY_READ;
          r.count_value = val;
        end
        cclh_pkg::ACT_RD_BIN: begin
          if (b.csel < NUM_COMBO && b.lsel < MAXLEN)
            val = len_hist[int'(b.csel)*MAXLEN + int'(b.lsel)];
          r.reply_kind  = cclh_pkg::REPLY_READ;
          r.count_value = val;
        end
        default: begin
          r.reply_kind  = cclh_pkg::REPLY_READ;
          r.count_value = line_count;
        end
      endcase
      awaited.push_back(r);
    endfunction

    task flag(input string msg);
      errors++;
      $display("mismatch @%0d: %s", cycle_count, msg);
    endtask

    // Compare one popped beat against the oldest waiting reply
    task check_reply(input cclh_pkg::res_t got);
      cclh_pkg::res_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected reply kind=%0d class=%0d len=%0d ovf=%0d count=%0h",
                       got.reply_kind, got.line_class, got.line_length,
                       got.length_overflow, got.count_value));
        return;
      end
      want = awaited.pop_front();
      if (got.reply_kind !== want.reply_kind)
        flag($sformatf("reply_kind %0d, want %0d", got.reply_kind, want.reply_kind));
      if (got.line_class !== want.line_class)
        flag($sformatf("line_class %0d, want %0d", got.line_class, want.line_class));
      if (got.line_length !== want.line_length)
        flag($sformatf("line_length %0d, want %0d", got.line_length, want.line_length));
      if (got.length_overflow !== want.length_overflow)
        flag($sformatf("length_overflow %0d, want %0d",
                       got.length_overflow, want.length_overflow));
      if (got.count_value !== want.count_value)
        flag($sformatf("count_value %0h, want %0h", got.count_value, want.count_value));
    endtask

    task close_out();
      if (awaited.size() != 0)
        flag($sformatf("%0d replies never arrived", awaited.size()));
    endtask
  endclass

  line_scoreboard sb;
  cclh_pkg::res_t seen_reply;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Result side: sample the beat at the rising edge
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      seen_reply.reply_kind      = reply_kind;
      seen_reply.line_class      = line_class;
      seen_reply.line_length     = line_length;
      seen_reply.length_overflow = length_overflow;
      seen_reply.count_value     = count_value;
      sb.check_reply(seen_reply);
    end
  end

  // Receiver stalls: the pattern follows bits 10:9 of the cycle count
  always @(negedge clk) begin
    if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (cycle_count[10:9])
        2'd0: pop <= 1'b1;
        2'd1: begin
          if ($urandom_range(0, 2) == 0) begin
            pop        <= 1'b0;
            stall_left <= $urandom_range(0, 2);
          end else begin
            pop <= 1'b1;
          end
        end
        2'd2: begin
          if ($urandom_range(0, 15) == 0) begin
            pop        <= 1'b0;
            stall_left <= $urandom_range(5, 24);
          end else begin
            pop <= 1'b1;
          end
        end
        default: pop <= cycle_count[0];
      endcase
    end
  end

  // Timeout
  initial begin
    wait (cycle_count >= LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one beat, hold it until taken, then note it; bursts end in random gaps
  task automatic send_beat(input cclh_pkg::action_t a, input logic [7:0] ch,
                           input logic [3:0] cs, input logic [3:0] ls);
    beat_t b;
    int    gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    push          <= 1'b1;
    action        <= a;
    char_byte     <= ch;
    class_select  <= cs;
    length_select <= ls;
    @(posedge clk);
    while (full) @(posedge clk);
    b.act  = a;
    b.ch   = ch;
    b.csel = cs;
    b.lsel = ls;
    sb.tally_beat(b);
    beats_sent++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_beat(cclh_pkg::ACT_BYTE, ch, 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 15)));
  endtask

  // Counter read with selectors mostly in range
  task automatic send_read();
    cclh_pkg::action_t a;
    logic [3:0]        cs;
    logic [3:0]        ls;
    a  = cclh_pkg::action_t'($urandom_range(1, 3));
    cs = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
    ls = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(12, 15))
                                     : 4'($urandom_range(0, 11));
    send_beat(a, 8'($urandom), cs, ls);
  endtask

  function automatic logic [7:0] other_byte();
    logic [7:0] x;
    do begin
      x = 8'($urandom);
    end while (char_class_mask(x) != MK_OTHER || x == LF);
    return x;
  endfunction

  // One well-formed line drawn from the given classes, reads mixed in
  task automatic send_line(input int len, input logic [3:0] kinds);
    int         k;
    logic [7:0] ch;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_read();
      do begin
        k = $urandom_range(0, 3);
      end while (!kinds[k]);
      case (k)
        0:       ch = 8'($urandom_range(8'h30, 8'h39));
        1:       ch = 8'($urandom_range(8'h61, 8'h7A));
        2:       ch = 8'($urandom_range(8'h41, 8'h5A));
        default: ch = other_byte();
      endcase
      send_char(ch);
    end
    send_char(LF);
  endtask

  // Stop offering beats until every reply has been popped
  task automatic drain_replies();
    @(negedge clk);
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // empty line; digit; lower; upper; other extremes; class boundaries; all four
    logic [7:0] text [] = '{LF,
                            8'h30, 8'h39, LF,
                            8'h61, 8'h7A, LF,
                            8'h41, 8'h5A, LF,
                            8'h00, 8'hFF, LF,
                            8'h2F, 8'h3A, 8'h60, 8'h7B, LF,
                            8'h35, 8'h6D, 8'h4D, 8'h7E, LF};
    foreach (text[i]) send_char(text[i]);
    send_beat(cclh_pkg::ACT_RD_TOTAL, 8'h00, 4'd0, 4'd0);
    send_beat(cclh_pkg::ACT_RD_BIN, 8'hFF, 4'd0, 4'd2);
    send_beat(cclh_pkg::ACT_RD_BIN, 8'h0A, 4'd14, 4'd11);
    send_beat(cclh_pkg::ACT_RD_GRAND, 8'h55, 4'd7, 4'd9);
    // bad class selector, bad length selectors
    send_beat(cclh_pkg::ACT_RD_TOTAL, 8'hAA, 4'd15, 4'd15);
    send_beat(cclh_pkg::ACT_RD_BIN, 8'h00, 4'd3, 4'd12);
    send_beat(cclh_pkg::ACT_RD_BIN, 8'hFF, 4'd15, 4'd15);
  endtask

  // Main stimulus
  initial begin
    int  r;
    bit  huge_done;
    bit  mid_drained;
    sb          = new();
    huge_done   = 1'b0;
    mid_drained = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    drain_replies();

    while (beats_sent < 2000) begin
      r = $urandom_range(0, 99);
      if (!huge_done && beats_sent > 600) begin
        // line long enough to saturate the length count
        send_line(1030, 4'($urandom_range(1, 15)));
        huge_done = 1'b1;
      end else if (!mid_drained && beats_sent > 1200) begin
        drain_replies();
        mid_drained = 1'b1;
      end else if (r < 12) begin
        send_read();
      end else if (r < 17) begin
        send_char(8'($urandom));
      end else if (r < 22) begin
        send_line($urandom_range(MAXLEN, 40), 4'($urandom_range(1, 15)));
      end else begin
        send_line($urandom_range(0, MAXLEN - 1), 4'($urandom_range(1, 15)));
      end
    end

    // Final reads of every combination total and the grand total
    for (int c = 0; c < NUM_COMBO; c++) begin
      send_beat(cclh_pkg::ACT_RD_TOTAL, 8'h00, 4'(c), 4'd0);
    end
    send_beat(cclh_pkg::ACT_RD_GRAND, 8'h00, 4'd0, 4'd0);

    @(negedge clk);
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cclh_pkg.sv
src/cclh_fifo.sv
src/cclh_front.sv
src/cclh_back.sv
src/char_class_line_histogram.sv
verif/char_class_line_histogram_tb.sv
